// ----- rtl/core/sequence_window_bitmap_core_assert.svh -----
// ----------------------------------------------------------------------------
// Sequence window bitmap core assertion macros
// Shared concurrent assertion forms used by the core modules.
// ----------------------------------------------------------------------------
`ifndef SEQUENCE_WINDOW_BITMAP_CORE_ASSERT_SVH
`define SEQUENCE_WINDOW_BITMAP_CORE_ASSERT_SVH

// Same-cycle implication.
`define SWB_ASSERT_IMPLIES(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication.
`define SWB_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- rtl/core/swb_pkg.sv -----
// ----------------------------------------------------------------------------
// Sequence window bitmap package
// Widths, request classes and helper functions shared by the core modules.
// ----------------------------------------------------------------------------
package swb_pkg;

   localparam int WINDOW      = 128;
   localparam int DIFF_W      = 16;
   localparam int RANGE_W     = 8;
   localparam int CNT_W       = 8;
   localparam int QUEUE_DEPTH = 2;

   localparam int GROUP_BITS  = 8;
   localparam int NUM_GROUPS  = WINDOW / GROUP_BITS;
   localparam int GROUP_CNT_W = $clog2(GROUP_BITS + 1);
   localparam int PART_GROUPS = 4;
   localparam int NUM_PARTS   = NUM_GROUPS / PART_GROUPS;
   localparam int PART_CNT_W  = $clog2(GROUP_BITS * PART_GROUPS + 1);

   localparam logic [RANGE_W-1:0] RANGE_RESET = RANGE_W'(64);

   typedef logic [WINDOW-1:0] bitmap_type;

   typedef enum logic [1:0] {
      CLS_OLD,
      CLS_FAR,
      CLS_SHIFT
   } cls_type;

   typedef struct packed {
      cls_type            cls;
      logic [RANGE_W-1:0] shamt;
      logic               mark;
      logic [CNT_W-1:0]   count_len;
   } cmd_type;

   function automatic logic [RANGE_W-1:0] eff_range(input logic [RANGE_W-1:0] raw);
      logic [RANGE_W-1:0] r;
      r = raw;
      if (raw == '0) begin
         r = RANGE_W'(1);
      end else if (raw > RANGE_W'(WINDOW)) begin
         r = RANGE_W'(WINDOW);
      end
      return r;
   endfunction

   function automatic logic [CNT_W-1:0] sat_count(input logic [CNT_W-1:0] raw);
      logic [CNT_W-1:0] c;
      c = raw;
      if (raw > CNT_W'(WINDOW)) begin
         c = CNT_W'(WINDOW);
      end
      return c;
   endfunction

   function automatic bitmap_type keep_below(input logic [RANGE_W-1:0] n);
      return ~({WINDOW{1'b1}} << n);
   endfunction

endpackage

// ----- rtl/core/swb_req_if.sv -----
// ----------------------------------------------------------------------------
// Sequence window bitmap request channel
// Valid/ready channel carrying one sequence distance request.
// ----------------------------------------------------------------------------
interface swb_req_if import swb_pkg::*; ();

   logic                     valid;
   logic                     ready;
   logic signed [DIFF_W-1:0] seq_diff;
   logic                     mark_flag;
   logic [CNT_W-1:0]         count_range;

   modport source (output valid, output seq_diff, output mark_flag, output count_range,
                   input ready);
   modport sink (input valid, input seq_diff, input mark_flag, input count_range,
                 output ready);

endinterface

// ----- rtl/core/swb_rsp_if.sv -----
// ----------------------------------------------------------------------------
// Sequence window bitmap response channel
// Valid/ready channel carrying the new flag and the received count.
// ----------------------------------------------------------------------------
interface swb_rsp_if import swb_pkg::*; ();

   logic             valid;
   logic             ready;
   logic             is_new;
   logic [CNT_W-1:0] received_count;

   modport source (output valid, output is_new, output received_count, input ready);
   modport sink (input valid, input is_new, input received_count, output ready);

endinterface

// ----- rtl/core/sequence_window_bitmap_core.sv -----
// A request passes the front-end register, the queue, then back-end stages a, b, c and rsp.
// Throughput: one request per cycle while the response side is ready.
// The bitmap update is a single register stage; the set-bit count is a three-stage adder tree.
// Reset clears the bitmap, empties the pipeline and queue, and sets the window range to 64.
// ----------------------------------------------------------------------------
// Sequence window bitmap core
// Tracks received sequence numbers in a sliding bitmap and reports the
// new flag and the number of received positions for each request.
// ----------------------------------------------------------------------------
module sequence_window_bitmap_core import swb_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               csr_we,
   input  logic [RANGE_W-1:0] csr_wdata,
   swb_req_if.sink            req_chan,
   swb_rsp_if.source          rsp_chan
);

   logic               q_push;
   logic               q_ready;
   cmd_type            q_push_cmd;
   logic               q_valid;
   cmd_type            q_pop_cmd;
   logic               q_pop;
   logic [RANGE_W-1:0] range_eff;

   swb_front u_front (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata),
      .req       (req_chan),
      .q_ready   (q_ready),
      .q_push    (q_push),
      .q_cmd     (q_push_cmd),
      .range_eff (range_eff)
   );

   swb_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_cmd  (q_push_cmd),
      .ready     (q_ready),
      .pop_valid (q_valid),
      .pop_cmd   (q_pop_cmd),
      .pop       (q_pop)
   );

   swb_back u_back (
      .clock     (clock),
      .reset     (reset),
      .range_eff (range_eff),
      .q_valid   (q_valid),
      .q_cmd     (q_pop_cmd),
      .q_pop     (q_pop),
      .rsp       (rsp_chan)
   );

endmodule

// ----- rtl/core/swb_front.sv -----
// ----------------------------------------------------------------------------
// Sequence window bitmap front end
// Holds the window range register, accepts requests and classifies them.
// ----------------------------------------------------------------------------
module swb_front import swb_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               csr_we,
   input  logic [RANGE_W-1:0] csr_wdata,
   swb_req_if.sink            req,
   input  logic               q_ready,
   output logic               q_push,
   output cmd_type            q_cmd,
   output logic [RANGE_W-1:0] range_eff
);

   logic [RANGE_W-1:0]     range_ff, range_in;
   cmd_type                cmd_ff, cmd_in;
   logic                   cmd_valid_ff, cmd_valid_in;
   logic                   accept;
   logic signed [DIFF_W:0] diff_ext;
   logic signed [DIFF_W:0] lim;
   logic signed [DIFF_W:0] neg_lim;

   assign range_eff = eff_range(range_ff);
   assign req.ready = !cmd_valid_ff || q_ready;
   assign accept    = req.valid && req.ready;
   assign q_push    = cmd_valid_ff;
   assign q_cmd     = cmd_ff;

   always_comb begin
      diff_ext = {req.seq_diff[DIFF_W-1], req.seq_diff};
      lim      = $signed({{(DIFF_W + 1 - RANGE_W){1'b0}}, range_eff});
      neg_lim  = -lim;
      cmd_in.mark      = req.mark_flag;
      cmd_in.count_len = req.count_range;
      cmd_in.shamt     = '0;
      if (diff_ext < 0 && diff_ext >= neg_lim) begin
         cmd_in.cls = CLS_OLD;
      end else if (diff_ext > lim || diff_ext < neg_lim) begin
         cmd_in.cls = CLS_FAR;
      end else begin
         cmd_in.cls   = CLS_SHIFT;
         cmd_in.shamt = req.seq_diff[RANGE_W-1:0];
      end
   end

   always_comb begin
      range_in = csr_we ? csr_wdata : range_ff;
      if (accept) begin
         cmd_valid_in = 1'b1;
      end else if (q_ready) begin
         cmd_valid_in = 1'b0;
      end else begin
         cmd_valid_in = cmd_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         range_ff     <= RANGE_RESET;
         cmd_valid_ff <= 1'b0;
      end else begin
         range_ff     <= range_in;
         cmd_valid_ff <= cmd_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         cmd_ff <= cmd_in;
      end
   end

endmodule

// ----- rtl/core/swb_queue.sv -----
// ----------------------------------------------------------------------------
// Sequence window bitmap command queue
// Short FIFO that decouples the front end from the bitmap back end.
// ----------------------------------------------------------------------------
`include "sequence_window_bitmap_core_assert.svh"

module swb_queue import swb_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  cmd_type push_cmd,
   output logic    ready,
   output logic    pop_valid,
   output cmd_type pop_cmd,
   input  logic    pop
);

   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int FILL_W = $clog2(QUEUE_DEPTH + 1);
   localparam logic [FILL_W-1:0] DEPTH_C = FILL_W'(QUEUE_DEPTH);

   cmd_type           entry_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [FILL_W-1:0] count_ff, count_in;
   logic              do_push, do_pop;

   assign ready     = count_ff < DEPTH_C;
   assign pop_valid = count_ff != '0;
   assign pop_cmd   = entry_ff[rd_ptr_ff];
   assign do_push   = push && ready;
   assign do_pop    = pop && pop_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

   `SWB_ASSERT_IMPLIES(a_queue_bound, clock, reset, 1'b1, count_ff <= DEPTH_C, "queue overfilled")
   `SWB_ASSERT_NEXT(a_queue_fill, clock, reset, do_push && !do_pop, count_ff == $past(count_ff) + 1'b1, "queue fill count did not rise on push")
   `SWB_ASSERT_NEXT(a_queue_drain, clock, reset, do_pop && !do_push, count_ff == $past(count_ff) - 1'b1, "queue fill count did not fall on pop")

endmodule

// ----- rtl/core/swb_back.sv -----
// ----------------------------------------------------------------------------
// Sequence window bitmap back end
// Updates the bitmap and counts the set bits through a short pipeline.
// ----------------------------------------------------------------------------
`include "sequence_window_bitmap_core_assert.svh"

module swb_back import swb_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic [RANGE_W-1:0] range_eff,
   input  logic               q_valid,
   input  cmd_type            q_cmd,
   output logic               q_pop,
   swb_rsp_if.source          rsp
);

   bitmap_type             bits_ff, bits_in;
   bitmap_type             next_bits;
   bitmap_type             range_mask;
   bitmap_type             shifted;
   bitmap_type             mark_bits;
   logic                   en;

   logic                   a_valid_ff, a_new_ff;
   bitmap_type             a_masked_ff;
   logic                   b_valid_ff, b_new_ff;
   logic [GROUP_CNT_W-1:0] b_cnt_ff [NUM_GROUPS];
   logic [GROUP_CNT_W-1:0] b_cnt_in [NUM_GROUPS];
   logic                   c_valid_ff, c_new_ff;
   logic [PART_CNT_W-1:0]  c_part_ff [NUM_PARTS];
   logic [PART_CNT_W-1:0]  c_part_in [NUM_PARTS];
   logic                   rsp_valid_ff, rsp_new_ff;
   logic [CNT_W-1:0]       rsp_count_ff, rsp_count_in;

   assign en    = !rsp_valid_ff || rsp.ready;
   assign q_pop = q_valid && en;

   always_comb begin
      range_mask = keep_below(range_eff);
      shifted    = bits_ff << q_cmd.shamt;
      mark_bits  = bitmap_type'(q_cmd.mark);
      case (q_cmd.cls)
         CLS_OLD: begin
            next_bits = bits_ff;
         end
         CLS_FAR: begin
            next_bits = mark_bits;
         end
         CLS_SHIFT: begin
            next_bits = (shifted & range_mask) | mark_bits;
         end
         default: begin
            next_bits = bits_ff;
         end
      endcase
      // With no update, trimming keeps bits beyond a newly written range cleared.
      bits_in = q_pop ? next_bits : (bits_ff & range_mask);
   end

   always_comb begin
      for (int g = 0; g < NUM_GROUPS; g++) begin
         b_cnt_in[g] = '0;
         for (int k = 0; k < GROUP_BITS; k++) begin
            b_cnt_in[g] = b_cnt_in[g] + GROUP_CNT_W'(a_masked_ff[g * GROUP_BITS + k]);
         end
      end
      for (int p = 0; p < NUM_PARTS; p++) begin
         c_part_in[p] = '0;
         for (int k = 0; k < PART_GROUPS; k++) begin
            c_part_in[p] = c_part_in[p] + PART_CNT_W'(b_cnt_ff[p * PART_GROUPS + k]);
         end
      end
      rsp_count_in = '0;
      for (int p = 0; p < NUM_PARTS; p++) begin
         rsp_count_in = rsp_count_in + CNT_W'(c_part_ff[p]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bits_ff      <= '0;
         a_valid_ff   <= 1'b0;
         b_valid_ff   <= 1'b0;
         c_valid_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         bits_ff <= bits_in;
         if (en) begin
            a_valid_ff   <= q_pop;
            b_valid_ff   <= a_valid_ff;
            c_valid_ff   <= b_valid_ff;
            rsp_valid_ff <= c_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         a_masked_ff  <= next_bits & keep_below(sat_count(q_cmd.count_len));
         a_new_ff     <= q_cmd.cls != CLS_OLD;
         b_cnt_ff     <= b_cnt_in;
         b_new_ff     <= a_new_ff;
         c_part_ff    <= c_part_in;
         c_new_ff     <= b_new_ff;
         rsp_count_ff <= rsp_count_in;
         rsp_new_ff   <= c_new_ff;
      end
   end

   assign rsp.valid          = rsp_valid_ff;
   assign rsp.is_new         = rsp_new_ff;
   assign rsp.received_count = rsp_count_ff;

   `SWB_ASSERT_IMPLIES(a_range_trim, clock, reset, $stable(range_eff), (bits_ff & ~keep_below(range_eff)) == '0, "bitmap holds bits beyond the window range")
   `SWB_ASSERT_IMPLIES(a_count_max, clock, reset, rsp_valid_ff, rsp_count_ff <= CNT_W'(WINDOW), "received count exceeds window size")
   `SWB_ASSERT_NEXT(a_pipe_advance, clock, reset, en && c_valid_ff, rsp_valid_ff, "pipeline dropped a request")
   `SWB_ASSERT_NEXT(a_old_hold, clock, reset, q_pop && q_cmd.cls == CLS_OLD && $stable(range_eff), bits_ff == $past(bits_ff), "old request changed the bitmap")

endmodule

// ----- test/tb_sequence_window_bitmap_core.sv -----
// ----------------------------------------------------------------------------
// Sequence window bitmap core testbench
// Drives sequence distance requests through the core under several window
// ranges and compares every response with a behavioral bitmap tracker kept in
// the bench, or with the table for fixed rows. A short table of directed
// requests and range writes comes first, then random phases with random idling
// on both channels, and one long response stall backs up to the request input.
// ----------------------------------------------------------------------------
module tb_sequence_window_bitmap_core;
   import swb_pkg::*;

   localparam int RESP_LATENCY     = 5;
   localparam int SETTLE_CYCLES    = 2 * RESP_LATENCY;
   localparam int CYCLE_LIMIT      = 600_000;
   localparam int MAX_REPORTS      = 10;
   localparam int LONG_HOLD_CYCLES = 300;
   localparam int NUM_PHASES       = 8;
   localparam int PHASE_REQUESTS   = 150;
   localparam int HOLD_PHASE       = 2;
   localparam int STEADY_PHASE     = 5;

   typedef enum logic {
      ROW_REQUEST,
      ROW_RANGE_WRITE
   } row_kind_type;

   typedef struct packed {
      row_kind_type       kind;
      logic [DIFF_W-1:0]  diff;
      logic               mark;
      logic [CNT_W-1:0]   span;
      logic [RANGE_W-1:0] range_value;
      logic               fixed;
      logic               exp_new;
      logic [CNT_W-1:0]   exp_count;
   } stim_row_type;

   typedef struct packed {
      logic             is_new;
      logic [CNT_W-1:0] received_count;
   } outcome_type;

   localparam int NUM_ROWS = 26;
   localparam stim_row_type DIRECTED [NUM_ROWS] = '{
      '{ROW_REQUEST,     16'sd0,     1'b0, 8'd128, 8'd0,   1'b1, 1'b1, 8'd0},
      '{ROW_REQUEST,     16'sd0,     1'b1, 8'd0,   8'd0,   1'b1, 1'b1, 8'd0},
      '{ROW_REQUEST,     16'sd0,     1'b1, 8'd255, 8'd0,   1'b1, 1'b1, 8'd1},
      '{ROW_REQUEST,     16'sd1,     1'b1, 8'd128, 8'd0,   1'b0, 1'b0, 8'd0},
      '{ROW_REQUEST,     -16'sd1,    1'b1, 8'd128, 8'd0,   1'b0, 1'b0, 8'd0},
      '{ROW_REQUEST,     -16'sd64,   1'b0, 8'd128, 8'd0,   1'b0, 1'b0, 8'd0},
      '{ROW_REQUEST,     16'sd64,    1'b1, 8'd128, 8'd0,   1'b0, 1'b0, 8'd0},
      '{ROW_REQUEST,     16'sd63,    1'b1, 8'd128, 8'd0,   1'b0, 1'b0, 8'd0},
      '{ROW_REQUEST,     -16'sd65,   1'b1, 8'd128, 8'd0,   1'b1, 1'b1, 8'd1},
      '{ROW_REQUEST,     16'sd65,    1'b0, 8'd128, 8'd0,   1'b1, 1'b1, 8'd0},
      '{ROW_REQUEST,     16'h7FFF,   1'b1, 8'd128, 8'd0,   1'b1, 1'b1, 8'd1},
      '{ROW_REQUEST,     16'h8000,   1'b0, 8'd200, 8'd0,   1'b1, 1'b1, 8'd0},
      '{ROW_REQUEST,     16'sd5,     1'b1, 8'd3,   8'd0,   1'b0, 1'b0, 8'd0},
      '{ROW_RANGE_WRITE, 16'sd0,     1'b0, 8'd0,   8'd0,   1'b0, 1'b0, 8'd0},
      '{ROW_REQUEST,     16'sd1,     1'b1, 8'd128, 8'd0,   1'b0, 1'b0, 8'd0},
      '{ROW_REQUEST,     -16'sd1,    1'b1, 8'd128, 8'd0,   1'b0, 1'b0, 8'd0},
      '{ROW_REQUEST,     16'sd2,     1'b1, 8'd128, 8'd0,   1'b1, 1'b1, 8'd1},
      '{ROW_RANGE_WRITE, 16'sd0,     1'b0, 8'd0,   8'd255, 1'b0, 1'b0, 8'd0},
      '{ROW_REQUEST,     16'sd127,   1'b1, 8'd128, 8'd0,   1'b0, 1'b0, 8'd0},
      '{ROW_REQUEST,     16'sd128,   1'b1, 8'd128, 8'd0,   1'b0, 1'b0, 8'd0},
      '{ROW_REQUEST,     -16'sd128,  1'b1, 8'd128, 8'd0,   1'b0, 1'b0, 8'd0},
      '{ROW_REQUEST,     16'sd5,     1'b1, 8'd128, 8'd0,   1'b0, 1'b0, 8'd0},
      '{ROW_RANGE_WRITE, 16'sd0,     1'b0, 8'd0,   8'd4,   1'b0, 1'b0, 8'd0},
      '{ROW_REQUEST,     16'sd0,     1'b0, 8'd128, 8'd0,   1'b0, 1'b0, 8'd0},
      '{ROW_REQUEST,     -16'sd4,    1'b1, 8'd4,   8'd0,   1'b0, 1'b0, 8'd0},
      '{ROW_REQUEST,     -16'sd5,    1'b0, 8'd128, 8'd0,   1'b1, 1'b1, 8'd0}
   };

   localparam logic [RANGE_W-1:0] PHASE_RANGES [NUM_PHASES] = '{
      8'd128, 8'd64, 8'd255, 8'd1, 8'd0, 8'd129, 8'd16, 8'd32
   };

   logic               clock;
   logic               reset;
   logic               csr_we;
   logic [RANGE_W-1:0] csr_wdata;
   logic               req_fixed;
   logic               req_fixed_new;
   logic [CNT_W-1:0]   req_fixed_count;

   swb_req_if req_chan ();
   swb_rsp_if rsp_chan ();

   bitmap_type         window_map;
   logic [RANGE_W-1:0] range_setting;
   outcome_type        pending_outcomes [$];
   outcome_type        outcome_now;
   outcome_type        outcome_want;
   int                 mismatches    = 0;
   int                 cycle_count   = 0;
   int                 hold_requests = 0;

   sequence_window_bitmap_core i_dut (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata),
      .req_chan  (req_chan),
      .rsp_chan  (rsp_chan)
   );

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   function automatic int eff_window(input logic [RANGE_W-1:0] raw);
      int r;
      r = int'(raw);
      if (r < 1) begin
         r = 1;
      end else if (r > WINDOW) begin
         r = WINDOW;
      end
      return r;
   endfunction

   function automatic bitmap_type low_mask(input int n);
      if (n >= WINDOW) begin
         return '1;
      end
      return (bitmap_type'(1) << n) - bitmap_type'(1);
   endfunction

   function automatic void apply_range(input logic [RANGE_W-1:0] value);
      range_setting = value;
      window_map &= low_mask(eff_window(value));
   endfunction

   function automatic outcome_type track_sequence(input logic signed [DIFF_W-1:0] diff,
                                                  input logic mark,
                                                  input logic [CNT_W-1:0] span);
      outcome_type result;
      bitmap_type  counted;
      int          d;
      int          r;
      int          c;
      int          ones;
      d = int'(diff);
      r = eff_window(range_setting);
      result.is_new = 1'b1;
      if (d < 0 && d >= -r) begin
         result.is_new = 1'b0;
      end else if (d > r || d < -r) begin
         window_map = '0;
         window_map[0] = mark;
      end else begin
         window_map = (window_map << d) & low_mask(r);
         if (mark) begin
            window_map[0] = 1'b1;
         end
      end
      c = (int'(span) > WINDOW) ? WINDOW : int'(span);
      counted = window_map & low_mask(c);
      ones = 0;
      for (int i = 0; i < WINDOW; i++) begin
         ones += int'(counted[i]);
      end
      result.received_count = CNT_W'(ones);
      return result;
   endfunction

   task automatic report_mismatch(input string what, input int want, input int got);
      mismatches++;
      if (mismatches <= MAX_REPORTS) begin
         $display("mismatch in %s: expected %0d, got %0d", what, want, got);
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         window_map = '0;
         range_setting = RANGE_RESET;
      end else begin
         if (csr_we) begin
            apply_range(csr_wdata);
         end
         if (rsp_chan.valid && rsp_chan.ready) begin
            if (pending_outcomes.size() == 0) begin
               mismatches++;
               if (mismatches <= MAX_REPORTS) begin
                  $display("unexpected response: is_new %0d, received_count %0d",
                           rsp_chan.is_new, rsp_chan.received_count);
               end
            end else begin
               outcome_want = pending_outcomes.pop_front();
               if (rsp_chan.is_new !== outcome_want.is_new) begin
                  report_mismatch("is_new", outcome_want.is_new, rsp_chan.is_new);
               end
               if (rsp_chan.received_count !== outcome_want.received_count) begin
                  report_mismatch("received_count", outcome_want.received_count,
                                  rsp_chan.received_count);
               end
            end
         end
         if (req_chan.valid && req_chan.ready) begin
            outcome_now = track_sequence(req_chan.seq_diff, req_chan.mark_flag,
                                         req_chan.count_range);
            if (req_fixed) begin
               outcome_now.is_new = req_fixed_new;
               outcome_now.received_count = req_fixed_count;
            end
            pending_outcomes.push_back(outcome_now);
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("FAILED: results differ");
         $finish;
      end
   end

   initial begin : response_side
      int run_left;
      int holds_served;
      int pick;
      run_left = 0;
      holds_served = 0;
      rsp_chan.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (holds_served < hold_requests) begin
            holds_served++;
            rsp_chan.ready <= 1'b0;
            run_left = LONG_HOLD_CYCLES;
         end else if (run_left > 0) begin
            run_left--;
         end else begin
            pick = $urandom_range(0, 99);
            if (pick < 60) begin
               rsp_chan.ready <= 1'b1;
               run_left = $urandom_range(0, 19);
            end else if (pick < 90) begin
               rsp_chan.ready <= 1'b0;
               run_left = $urandom_range(0, 2);
            end else begin
               rsp_chan.ready <= 1'b0;
               run_left = $urandom_range(9, 39);
            end
         end
      end
   end

   function automatic int pick_gap(input bit allow);
      int pick;
      pick = $urandom_range(0, 99);
      if (!allow || pick < 75) begin
         return 0;
      end else if (pick < 95) begin
         return $urandom_range(1, 3);
      end
      return $urandom_range(10, 40);
   endfunction

   task automatic send_request(input logic [DIFF_W-1:0] diff, input logic mark,
                               input logic [CNT_W-1:0] span, input logic fixed,
                               input logic fixed_new, input logic [CNT_W-1:0] fixed_count,
                               input int gap);
      if (gap > 0) begin
         req_chan.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_chan.valid       <= 1'b1;
      req_chan.seq_diff    <= diff;
      req_chan.mark_flag   <= mark;
      req_chan.count_range <= span;
      req_fixed            <= fixed;
      req_fixed_new        <= fixed_new;
      req_fixed_count      <= fixed_count;
      do begin
         @(posedge clock);
      end while (!req_chan.ready);
   endtask

   task automatic drain_responses();
      req_chan.valid <= 1'b0;
      @(posedge clock);
      while (pending_outcomes.size() != 0) begin
         @(posedge clock);
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_range(input logic [RANGE_W-1:0] value);
      drain_responses();
      csr_we    <= 1'b1;
      csr_wdata <= value;
      @(posedge clock);
      csr_we    <= 1'b0;
   endtask

   initial begin : stimulus
      int                        r;
      int                        sel;
      logic [RANGE_W-1:0]        value;
      logic signed [DIFF_W-1:0]  diff;
      logic                      mark;
      logic [CNT_W-1:0]          span;
      bit                        gaps_on;
      reset                <= 1'b1;
      csr_we               <= 1'b0;
      csr_wdata            <= '0;
      req_chan.valid       <= 1'b0;
      req_chan.seq_diff    <= '0;
      req_chan.mark_flag   <= 1'b0;
      req_chan.count_range <= '0;
      req_fixed            <= 1'b0;
      req_fixed_new        <= 1'b0;
      req_fixed_count      <= '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      for (int i = 0; i < NUM_ROWS; i++) begin
         if (DIRECTED[i].kind == ROW_RANGE_WRITE) begin
            write_range(DIRECTED[i].range_value);
         end else begin
            send_request(DIRECTED[i].diff, DIRECTED[i].mark, DIRECTED[i].span,
                         DIRECTED[i].fixed, DIRECTED[i].exp_new, DIRECTED[i].exp_count,
                         pick_gap(1'b1));
         end
      end

      for (int p = 0; p < NUM_PHASES; p++) begin
         value = (p == NUM_PHASES - 1) ? RANGE_W'($urandom_range(0, 255)) : PHASE_RANGES[p];
         write_range(value);
         r = eff_window(value);
         gaps_on = (p != HOLD_PHASE && p != STEADY_PHASE);
         if (p == HOLD_PHASE) begin
            hold_requests++;
         end
         for (int n = 0; n < PHASE_REQUESTS; n++) begin
            sel = $urandom_range(0, 99);
            mark = ($urandom_range(0, 99) < 85);
            if (sel < 45) begin
               diff = DIFF_W'($urandom_range(0, (r > 3) ? 3 : r));
            end else if (sel < 60) begin
               diff = DIFF_W'($urandom_range(0, r));
            end else if (sel < 75) begin
               diff = -DIFF_W'($urandom_range(1, r));
            end else if (sel < 85) begin
               case ($urandom_range(0, 3))
                  0: diff = DIFF_W'(r);
                  1: diff = -DIFF_W'(r);
                  2: diff = DIFF_W'(r + 1);
                  default: diff = -DIFF_W'(r + 1);
               endcase
            end else begin
               diff = DIFF_W'($urandom);
               mark = $urandom_range(0, 1);
            end
            sel = $urandom_range(0, 99);
            if (sel < 70) begin
               span = CNT_W'($urandom_range(0, WINDOW));
            end else if (sel < 85) begin
               span = CNT_W'($urandom_range(0, r));
            end else begin
               span = CNT_W'($urandom_range(0, 255));
            end
            send_request(diff, mark, span, 1'b0, 1'b0, '0, pick_gap(gaps_on));
         end
      end

      drain_responses();
      mismatches += pending_outcomes.size();
      if (mismatches == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

endmodule

// ----- files.f -----
+incdir+rtl/core
rtl/core/swb_pkg.sv
rtl/core/swb_req_if.sv
rtl/core/swb_rsp_if.sv
rtl/core/swb_front.sv
rtl/core/swb_queue.sv
rtl/core/swb_back.sv
rtl/core/sequence_window_bitmap_core.sv
test/tb_sequence_window_bitmap_core.sv
